/* hdl/lru_batch_prune_key_cache_core_assert.svh */
// assertion macros for the key cache core
// used by the top level; expects clk and arst_n in the including scope
`ifndef LRU_BATCH_PRUNE_KEY_CACHE_CORE_ASSERT_SVH
`define LRU_BATCH_PRUNE_KEY_CACHE_CORE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define LBPK_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define LBPK_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/lbpk_pkg.sv */
// shared constants and types for the key cache core
// no dependencies
`default_nettype none

package lbpk_pkg;

	// table geometry
	localparam int CAPACITY    = 64;
	localparam int PRUNE_COUNT = 8;
	localparam int SLOT_W      = $clog2(CAPACITY);
	localparam int CNT_W       = SLOT_W + 1;

	// field widths
	localparam int ID_W       = 32;
	localparam int KEY_W      = 2 * ID_W;
	localparam int STAMP_W    = 32;
	localparam int SLOT_OUT_W = 6;

	// result kinds
	localparam logic KIND_EVICT  = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	// control of the oldest-entry list
	typedef struct packed {
		logic clear;
		logic insert;
		logic pop;
	} list_ctl_t;

endpackage

`default_nettype wire

/* hdl/lbpk_ram.sv */
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none

module lbpk_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, holds while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* hdl/lbpk_oldest.sv */
// sorted list of the oldest entries seen during a table scan
// depends on lbpk_pkg
`default_nettype none

module lbpk_oldest
	import lbpk_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire list_ctl_t          ctl,
	input  wire logic [STAMP_W-1:0] in_stamp,
	input  wire logic [SLOT_W-1:0]  in_slot,
	output logic                    head_v,
	output logic      [SLOT_W-1:0]  head_slot
);

	logic [PRUNE_COUNT-1:0] v_q;
	logic [PRUNE_COUNT-1:0] gt;
	logic [PRUNE_COUNT-1:0] ins_v;
	logic [PRUNE_COUNT-1:0] pop_v;
	logic [STAMP_W-1:0]     stamp_q   [PRUNE_COUNT];
	logic [SLOT_W-1:0]      slot_q    [PRUNE_COUNT];
	logic [STAMP_W-1:0]     ins_stamp [PRUNE_COUNT];
	logic [SLOT_W-1:0]      ins_slot  [PRUNE_COUNT];
	logic [STAMP_W-1:0]     pop_stamp [PRUNE_COUNT];
	logic [SLOT_W-1:0]      pop_slot  [PRUNE_COUNT];

	for (genvar j = 0; j < PRUNE_COUNT; j++) begin : g_ent
		// new word sorts before this entry; ties keep the earlier slot in front
		assign gt[j] = ~v_q[j] | (in_stamp < stamp_q[j]);

		// insert source: the new word at the first greater place, else the left neighbor
		if (j == 0) begin : g_head
			assign ins_v[j]     = 1'b1;
			assign ins_stamp[j] = in_stamp;
			assign ins_slot[j]  = in_slot;
		end else begin : g_tail
			logic take_new;
			assign take_new     = gt[j] & ~gt[j-1];
			assign ins_v[j]     = take_new | v_q[j-1];
			assign ins_stamp[j] = take_new ? in_stamp : stamp_q[j-1];
			assign ins_slot[j]  = take_new ? in_slot : slot_q[j-1];
		end

		// pop source: the right neighbor, empty at the end
		if (j == PRUNE_COUNT - 1) begin : g_last
			assign pop_v[j]     = 1'b0;
			assign pop_stamp[j] = stamp_q[j];
			assign pop_slot[j]  = slot_q[j];
		end else begin : g_mid
			assign pop_v[j]     = v_q[j+1];
			assign pop_stamp[j] = stamp_q[j+1];
			assign pop_slot[j]  = slot_q[j+1];
		end

		// occupancy
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[j] <= 1'b0;
			end else if (ctl.clear) begin
				v_q[j] <= 1'b0;
			end else if (ctl.insert && gt[j]) begin
				v_q[j] <= ins_v[j];
			end else if (ctl.pop) begin
				v_q[j] <= pop_v[j];
			end
		end

		// stamp and slot
		always_ff @(posedge clk) begin
			if (ctl.insert && gt[j]) begin
				stamp_q[j] <= ins_stamp[j];
				slot_q[j]  <= ins_slot[j];
			end else if (ctl.pop) begin
				stamp_q[j] <= pop_stamp[j];
				slot_q[j]  <= pop_slot[j];
			end
		end
	end

	assign head_v    = v_q[0];
	assign head_slot = slot_q[0];

endmodule

`default_nettype wire

/* hdl/lru_batch_prune_key_cache_core.sv */
// fully associative key cache with batch eviction of the least recently used entries
// depends on lbpk_pkg, lbpk_ram, lbpk_oldest and the assertion macro header
// input channel s_*: one word per lookup, key = {program_id, decl_id} in s_tdata
// output channel m_*: zero or more eviction words (m_tuser = 0), then one lookup
// result (m_tuser = 1, m_tlast = 1) with hit flag, slot and the echoed key
// one lookup at a time: s_tready is high only while no lookup is in progress
// a lookup scans the key and stamp memories one slot per cycle through their read
// ports; a hit ends the scan early, and a miss on a full table then evicts entries,
// each eviction reading its key back from the key memory
// the oldest entries are collected in a sorted list during that same scan
// results sit in an output register; a stalled receiver holds the lookup in
// progress, while a new lookup is accepted as soon as its final word is registered
// reset clears the valid bits, the fill count and the use counter;
// memory contents are not cleared, and unwritten words that a scan reads are never used
`default_nettype none
`include "lru_batch_prune_key_cache_core_assert.svh"

module lru_batch_prune_key_cache_core
	import lbpk_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input: [31:0] decl_id, [63:32] program_id
	input  wire logic [63:0] s_tdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// output: [0] hit, [6:1] slot, [38:7] key_decl, [70:39] key_program, [71] zero
	output logic      [71:0] m_tdata,
	// output: [0] item_kind
	output logic             m_tuser,
	output logic             m_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_EV_RD  = 3'd2;
	localparam logic [2:0] ST_EV_OUT = 3'd3;
	localparam logic [2:0] ST_FINAL  = 3'd4;

	logic [2:0]          state_q;
	logic [ID_W-1:0]     decl_q;
	logic [ID_W-1:0]     prog_q;
	logic [CNT_W-1:0]    issue_q;
	logic                rd_v_s1;
	logic [SLOT_W-1:0]   idx_s1;
	logic                hit_q;
	logic [SLOT_W-1:0]   slot_q;
	logic                free_v_q;
	logic [SLOT_W-1:0]   free_q;
	logic [CAPACITY-1:0] valid_q;
	logic [CNT_W-1:0]    fill_q;
	logic [STAMP_W-1:0]  counter_q;

	logic                  out_v_q;
	logic                  out_kind_q;
	logic                  out_hit_q;
	logic [SLOT_OUT_W-1:0] out_slot_q;
	logic [ID_W-1:0]       out_decl_q;
	logic [ID_W-1:0]       out_prog_q;
	logic                  out_last_q;

	logic               in_acc;
	logic               out_free;
	logic               scan_issue;
	logic               scan_proc;
	logic               ent_valid;
	logic               match;
	logic               last_ent;
	logic               table_full;
	logic               ev_load;
	logic               fin_load;
	logic [SLOT_W-1:0]  fin_slot;
	logic [STAMP_W-1:0] fin_stamp;
	logic               head_v;
	logic [SLOT_W-1:0]  head_slot;
	list_ctl_t          list_ctl;

	logic               key_re;
	logic [SLOT_W-1:0]  key_raddr;
	logic [KEY_W-1:0]   key_rdata;
	logic               key_we;
	logic [STAMP_W-1:0] stamp_rdata;

	// handshake and control decode
	assign s_tready   = (state_q == ST_IDLE);
	assign in_acc     = s_tvalid && s_tready;
	assign out_free   = !out_v_q || m_tready;
	assign scan_issue = (state_q == ST_SCAN) && (issue_q != CNT_W'(CAPACITY));
	assign scan_proc  = (state_q == ST_SCAN) && rd_v_s1;
	assign ent_valid  = valid_q[idx_s1];
	assign match      = ent_valid && (key_rdata == {decl_q, prog_q});
	assign last_ent   = (idx_s1 == SLOT_W'(CAPACITY - 1));
	assign table_full = (fill_q == CNT_W'(CAPACITY));
	assign ev_load    = (state_q == ST_EV_OUT) && out_free;
	assign fin_load   = (state_q == ST_FINAL) && out_free;
	assign fin_slot   = hit_q ? slot_q : (free_v_q ? free_q : '0);
	assign fin_stamp  = hit_q ? (counter_q + STAMP_W'(1)) : (counter_q + STAMP_W'(2));

	// memory ports
	assign key_re    = scan_issue || (state_q == ST_EV_RD);
	assign key_raddr = (state_q == ST_SCAN) ? issue_q[SLOT_W-1:0] : head_slot;
	assign key_we    = fin_load && !hit_q;

	// oldest-entry list control
	assign list_ctl.clear  = in_acc;
	assign list_ctl.insert = scan_proc && ent_valid && !match;
	assign list_ctl.pop    = ev_load;

	lbpk_ram #(
		.WIDTH(KEY_W),
		.DEPTH(CAPACITY)
	) u_key_ram (
		.clk  (clk),
		.re   (key_re),
		.raddr(key_raddr),
		.rdata(key_rdata),
		.we   (key_we),
		.waddr(fin_slot),
		.wdata({decl_q, prog_q})
	);

	lbpk_ram #(
		.WIDTH(STAMP_W),
		.DEPTH(CAPACITY)
	) u_stamp_ram (
		.clk  (clk),
		.re   (scan_issue),
		.raddr(issue_q[SLOT_W-1:0]),
		.rdata(stamp_rdata),
		.we   (fin_load),
		.waddr(fin_slot),
		.wdata(fin_stamp)
	);

	lbpk_oldest u_oldest (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (list_ctl),
		.in_stamp (stamp_rdata),
		.in_slot  (idx_s1),
		.head_v   (head_v),
		.head_slot(head_slot)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			issue_q  <= '0;
			rd_v_s1  <= 1'b0;
			hit_q    <= 1'b0;
			free_v_q <= 1'b0;
		end else begin
			rd_v_s1 <= scan_issue;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						issue_q  <= '0;
						hit_q    <= 1'b0;
						free_v_q <= 1'b0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_issue) begin
						issue_q <= issue_q + CNT_W'(1);
					end
					if (scan_proc) begin
						if (!ent_valid && !free_v_q) begin
							free_v_q <= 1'b1;
						end
						if (match) begin
							hit_q   <= 1'b1;
							state_q <= ST_FINAL;
						end else if (last_ent) begin
							state_q <= table_full ? ST_EV_RD : ST_FINAL;
						end
					end
				end
				ST_EV_RD: begin
					state_q <= head_v ? ST_EV_OUT : ST_FINAL;
				end
				ST_EV_OUT: begin
					if (out_free) begin
						free_v_q <= 1'b1;
						state_q  <= ST_EV_RD;
					end
				end
				ST_FINAL: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// per-lookup payload: key, scan index, hit slot, lowest free slot
	always_ff @(posedge clk) begin
		if (in_acc) begin
			decl_q <= s_tdata[ID_W-1:0];
			prog_q <= s_tdata[2*ID_W-1:ID_W];
		end
		idx_s1 <= issue_q[SLOT_W-1:0];
		if (scan_proc && match) begin
			slot_q <= idx_s1;
		end
		if (scan_proc && !ent_valid && !free_v_q) begin
			free_q <= idx_s1;
		end else if (ev_load && (!free_v_q || (head_slot < free_q))) begin
			free_q <= head_slot;
		end
	end

	// table occupancy and use counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			fill_q    <= '0;
			counter_q <= '0;
		end else if (ev_load) begin
			valid_q[head_slot] <= 1'b0;
			fill_q             <= fill_q - CNT_W'(1);
		end else if (fin_load) begin
			counter_q <= fin_stamp;
			if (!hit_q) begin
				valid_q[fin_slot] <= 1'b1;
				if (!valid_q[fin_slot]) begin
					fill_q <= fill_q + CNT_W'(1);
				end
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (ev_load || fin_load) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	// output register word
	always_ff @(posedge clk) begin
		if (ev_load) begin
			out_kind_q <= KIND_EVICT;
			out_hit_q  <= 1'b0;
			out_slot_q <= SLOT_OUT_W'(head_slot);
			out_decl_q <= key_rdata[KEY_W-1:ID_W];
			out_prog_q <= key_rdata[ID_W-1:0];
			out_last_q <= 1'b0;
		end else if (fin_load) begin
			out_kind_q <= KIND_LOOKUP;
			out_hit_q  <= hit_q;
			out_slot_q <= SLOT_OUT_W'(fin_slot);
			out_decl_q <= decl_q;
			out_prog_q <= prog_q;
			out_last_q <= 1'b1;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {1'b0, out_prog_q, out_decl_q, out_slot_q, out_hit_q};

	// checks
	`LBPK_ASSERT_SAME(a_fill_matches_valid, 1'b1, $countones(valid_q) == fill_q, "fill count differs from valid bits")
	`LBPK_ASSERT_NEXT(a_evict_drops_fill, ev_load, fill_q == CNT_W'($past(fill_q) - CNT_W'(1)), "eviction did not reduce fill count")
	`LBPK_ASSERT_NEXT(a_miss_sets_valid, fin_load && !hit_q, valid_q[$past(fin_slot)], "inserted slot not valid")

endmodule

`default_nettype wire
